// ----- sv/cnf3_clause_unit_propagate_assert.svh -----
// Assertion macros used by the checker file of the clause unit.
// Needs a clock named clock and a synchronous active-high reset named reset.
`ifndef CNF3_CLAUSE_UNIT_PROPAGATE_ASSERT_SVH
`define CNF3_CLAUSE_UNIT_PROPAGATE_ASSERT_SVH

// same-cycle implication
`define CUP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define CUP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- sv/cup_pkg.sv -----
// Shared constants; state, slot, command and status types.
// No dependencies.
package cup_pkg;

   localparam int NUM_VARS   = 1024;
   localparam int ADDR_W     = $clog2(NUM_VARS);
   localparam int CMD_W      = 2;
   localparam int VAR_W      = 10;
   localparam int VAL_W      = 2;
   localparam int LIT_W      = 11;
   localparam int CNT_W      = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PROP   = 2'd2;

   localparam logic [VAL_W-1:0] VAL_TRUE  = 2'b01;
   localparam logic [VAL_W-1:0] VAL_FALSE = 2'b11;
   localparam logic [VAL_W-1:0] VAL_UNDEF = 2'b00;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ASSIGN,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_FIN
   } cup_state_type;

   typedef enum logic [1:0] {
      SLOT_A,
      SLOT_B,
      SLOT_C
   } cup_slot_type;

   typedef struct packed {
      logic         clear_wr;
      logic         capture;
      logic         rd_en;
      cup_slot_type rd_slot;
      logic         acc_en;
      cup_slot_type acc_slot;
      logic         assign_wr;
      logic         fin;
   } cup_cmd_type;

   typedef struct packed {
      logic clear_last;
   } cup_status_type;

endpackage

// ----- sv/cup_ctrl.sv -----
// Controller of the clause unit: sequences clearing, assign and clause items.
// Depends on cup_pkg.
module cup_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [cup_pkg::CMD_W-1:0]   req_cmd,
   output logic                        req_tready,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output cup_pkg::cup_cmd_type        ctrl,
   input  cup_pkg::cup_status_type     status
);
   import cup_pkg::*;

   cup_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = (req_cmd == CMD_ASSIGN) ? ST_ASSIGN : ST_RD0;
         end
         ST_ASSIGN: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: state_in = ST_RD2;
         ST_RD2: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctrl       = '0;
      ctrl.rd_slot  = SLOT_A;
      ctrl.acc_slot = SLOT_A;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: ctrl.clear_wr = 1'b1;
         ST_IDLE: begin
            req_tready   = 1'b1;
            ctrl.capture = req_tvalid;
         end
         ST_ASSIGN: ctrl.assign_wr = out_free;
         ST_RD0: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_slot = SLOT_A;
         end
         ST_RD1: begin
            ctrl.rd_en    = 1'b1;
            ctrl.rd_slot  = SLOT_B;
            ctrl.acc_en   = 1'b1;
            ctrl.acc_slot = SLOT_A;
         end
         ST_RD2: begin
            ctrl.rd_en    = 1'b1;
            ctrl.rd_slot  = SLOT_C;
            ctrl.acc_en   = 1'b1;
            ctrl.acc_slot = SLOT_B;
         end
         ST_FIN: ctrl.fin = out_free;
         default: ctrl = '0;
      endcase
   end

   always_comb begin
      if (ctrl.fin || ctrl.assign_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- sv/cup_datapath.sv -----
// Datapath of the clause unit: assignment store, slot evaluation, result register.
// Depends on cup_pkg; driven by cup_ctrl.
module cup_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  cup_pkg::cup_cmd_type               ctrl,
   output cup_pkg::cup_status_type            status,
   input  logic [cup_pkg::CMD_W-1:0]          in_cmd,
   input  logic [cup_pkg::VAR_W-1:0]          in_var_index,
   input  logic signed [cup_pkg::VAL_W-1:0]   in_var_value,
   input  logic signed [cup_pkg::LIT_W-1:0]   in_lit_a,
   input  logic signed [cup_pkg::LIT_W-1:0]   in_lit_b,
   input  logic signed [cup_pkg::LIT_W-1:0]   in_lit_c,
   output logic                               satisfied,
   output logic                               complete,
   output logic [cup_pkg::CNT_W-1:0]          undefined_count,
   output logic                               propagated,
   output logic [cup_pkg::VAR_W-1:0]          propagated_var
);
   import cup_pkg::*;

   function automatic logic [LIT_W-1:0] lit_mag(input logic [LIT_W-1:0] lit);
      lit_mag = lit[LIT_W-1] ? LIT_W'(~lit + LIT_W'(1)) : lit;
   endfunction

   function automatic logic lit_in_range(input logic [LIT_W-1:0] lit);
      lit_in_range = 32'(lit_mag(lit)) < NUM_VARS;
   endfunction

   logic [VAL_W-1:0] mem [NUM_VARS];
   logic [VAL_W-1:0] rd_data_ff;

   // captured item
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [VAR_W-1:0] var_index_ff, var_index_in;
   logic [VAL_W-1:0] var_value_ff, var_value_in;
   logic [LIT_W-1:0] lit_a_ff, lit_a_in, lit_b_ff, lit_b_in, lit_c_ff, lit_c_in;

   // running sums over slots
   logic             sat_ff, sat_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LIT_W-1:0] unit_ff, unit_in;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic             sat_out_ff, sat_out_in, cmpl_out_ff, cmpl_out_in;
   logic [CNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic             prop_out_ff, prop_out_in;
   logic [VAR_W-1:0] pvar_out_ff, pvar_out_in;

   logic [LIT_W-1:0]  rd_lit, ev_lit, sum_unit;
   cup_slot_type      ev_slot;
   logic [ADDR_W-1:0] rd_addr, prop_addr, wr_addr;
   logic [VAL_W-1:0]  ev_val, wr_data;
   logic              ev_undef, ev_sat, sum_sat, prop, wr_en;
   logic [CNT_W-1:0]  sum_cnt;

   assign cmd_in       = ctrl.capture ? in_cmd       : cmd_ff;
   assign var_index_in = ctrl.capture ? in_var_index : var_index_ff;
   assign var_value_in = ctrl.capture ? in_var_value : var_value_ff;
   assign lit_a_in     = ctrl.capture ? in_lit_a     : lit_a_ff;
   assign lit_b_in     = ctrl.capture ? in_lit_b     : lit_b_ff;
   assign lit_c_in     = ctrl.capture ? in_lit_c     : lit_c_ff;

   always_comb begin
      case (ctrl.rd_slot)
         SLOT_A:  rd_lit = lit_a_ff;
         SLOT_B:  rd_lit = lit_b_ff;
         default: rd_lit = lit_c_ff;
      endcase
   end
   assign rd_addr = ADDR_W'(lit_mag(rd_lit));

   // slot C is folded in combinationally on the finishing cycle
   assign ev_slot = ctrl.fin ? SLOT_C : ctrl.acc_slot;
   always_comb begin
      case (ev_slot)
         SLOT_A:  ev_lit = lit_a_ff;
         SLOT_B:  ev_lit = lit_b_ff;
         default: ev_lit = lit_c_ff;
      endcase
   end

   assign ev_val   = lit_in_range(ev_lit) ? rd_data_ff : VAL_UNDEF;
   assign ev_undef = (ev_val == VAL_UNDEF);
   assign ev_sat   = !ev_undef && (ev_lit[LIT_W-1] ? ev_val[VAL_W-1] : !ev_val[VAL_W-1]);
   assign sum_sat  = sat_ff | ev_sat;
   assign sum_cnt  = cnt_ff + CNT_W'(ev_undef);
   assign sum_unit = ev_undef ? ev_lit : unit_ff;

   always_comb begin
      if (ctrl.capture) begin
         sat_in  = 1'b0;
         cnt_in  = '0;
         unit_in = '0;
      end else if (ctrl.acc_en) begin
         sat_in  = sum_sat;
         cnt_in  = sum_cnt;
         unit_in = sum_unit;
      end else begin
         sat_in  = sat_ff;
         cnt_in  = cnt_ff;
         unit_in = unit_ff;
      end
   end

   assign prop = ctrl.fin && (cmd_ff == CMD_PROP) && !sum_sat
                 && (sum_cnt == CNT_W'(1)) && lit_in_range(sum_unit);
   assign prop_addr = ADDR_W'(lit_mag(sum_unit));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = VAL_UNDEF;
      if (ctrl.clear_wr) begin
         wr_en = 1'b1;
      end else if (ctrl.assign_wr) begin
         wr_en   = 32'(var_index_ff) < NUM_VARS;
         wr_addr = ADDR_W'(var_index_ff);
         wr_data = var_value_ff;
      end else if (prop) begin
         wr_en   = 1'b1;
         wr_addr = prop_addr;
         wr_data = sum_unit[LIT_W-1] ? VAL_FALSE : VAL_TRUE;
      end
   end

   assign clr_addr_in       = ctrl.clear_wr ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   assign status.clear_last = (clr_addr_ff == ADDR_W'(NUM_VARS - 1));

   // assign items report all zeros
   always_comb begin
      sat_out_in  = sat_out_ff;
      cmpl_out_in = cmpl_out_ff;
      cnt_out_in  = cnt_out_ff;
      prop_out_in = prop_out_ff;
      pvar_out_in = pvar_out_ff;
      if (ctrl.fin) begin
         sat_out_in  = sum_sat;
         cmpl_out_in = (sum_cnt == '0);
         cnt_out_in  = sum_cnt;
         prop_out_in = prop;
         pvar_out_in = prop ? VAR_W'(prop_addr) : '0;
      end else if (ctrl.assign_wr) begin
         sat_out_in  = 1'b0;
         cmpl_out_in = 1'b0;
         cnt_out_in  = '0;
         prop_out_in = 1'b0;
         pvar_out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (ctrl.rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      var_index_ff <= var_index_in;
      var_value_ff <= var_value_in;
      lit_a_ff     <= lit_a_in;
      lit_b_ff     <= lit_b_in;
      lit_c_ff     <= lit_c_in;
      sat_ff       <= sat_in;
      cnt_ff       <= cnt_in;
      unit_ff      <= unit_in;
      sat_out_ff   <= sat_out_in;
      cmpl_out_ff  <= cmpl_out_in;
      cnt_out_ff   <= cnt_out_in;
      prop_out_ff  <= prop_out_in;
      pvar_out_ff  <= pvar_out_in;
   end

   assign satisfied       = sat_out_ff;
   assign complete        = cmpl_out_ff;
   assign undefined_count = cnt_out_ff;
   assign propagated      = prop_out_ff;
   assign propagated_var  = pvar_out_ff;

endmodule

// ----- sv/cnf3_clause_unit_propagate.sv -----
// Top level of the 3-CNF clause evaluator with unit propagation.
// Depends on cup_pkg, cup_ctrl and cup_datapath.
//
//   channel | dir | ports                        | carries
//   req     | in  | req_tvalid/tready/tdata/tuser | assign or clause item
//   rsp     | out | rsp_tvalid/tready/tdata       | one result item per input item
//
// A clause item goes from acceptance to result via accept, three reads and
// finish; an assign item via accept and assign. The three literals are read
// one after the other through the single read port of the assignment store.
// After reset all NUM_VARS (1024) entries of the store are cleared, during
// which req_tready stays low. A stalled result holds the finish step until
// taken; the next item is accepted in the cycle after the result is loaded.
module cnf3_clause_unit_propagate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // var_index[9:0], var_value[11:10], lit_a[22:12], lit_b[33:23], lit_c[44:34]
   input  logic [cup_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [cup_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // satisfied[0], complete[1], undefined_count[3:2], propagated[4],
   // propagated_var[14:5]
   output logic [cup_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cup_pkg::*;

   cup_cmd_type      ctrl;
   cup_status_type   status;
   logic             satisfied, complete, propagated;
   logic [CNT_W-1:0] undefined_count;
   logic [VAR_W-1:0] propagated_var;

   cup_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .ctrl       (ctrl),
      .status     (status)
   );

   cup_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .in_cmd          (req_tuser),
      .in_var_index    (req_tdata[9:0]),
      .in_var_value    (req_tdata[11:10]),
      .in_lit_a        (req_tdata[22:12]),
      .in_lit_b        (req_tdata[33:23]),
      .in_lit_c        (req_tdata[44:34]),
      .satisfied       (satisfied),
      .complete        (complete),
      .undefined_count (undefined_count),
      .propagated      (propagated),
      .propagated_var  (propagated_var)
   );

   assign rsp_tdata = {1'b0, propagated_var, propagated, undefined_count, complete, satisfied};

endmodule

// ----- sv/cup_checker.sv -----
// Port-level checks of the clause unit, bound to the top level.
// Depends on cup_pkg and cnf3_clause_unit_propagate_assert.svh.
`include "cnf3_clause_unit_propagate_assert.svh"

module cup_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cup_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import cup_pkg::*;

   // a stalled result item holds
   `CUP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one item at a time: no acceptance right after an acceptance
   `CUP_ASSERT_NEXT(a_req_one_at_a_time, req_tvalid && req_tready, !req_tready)

   // assign results are all zero, so only complete => no open slot holds for every item
   `CUP_ASSERT_NOW(a_complete_no_undef, rsp_tvalid && rsp_tdata[1], rsp_tdata[3:2] == 2'd0)

   // propagation only from an unsatisfied clause with one open slot
   `CUP_ASSERT_NOW(a_prop_unit, rsp_tvalid && rsp_tdata[4], !rsp_tdata[0] && rsp_tdata[3:2] == 2'd1)

   `CUP_ASSERT_NOW(a_pvar_zero, rsp_tvalid && !rsp_tdata[4], rsp_tdata[14:5] == '0)

endmodule

bind cnf3_clause_unit_propagate cup_checker u_cup_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
